FILE: design/utf8_stream_decoder_macros.svh
// assertion macros shared by the utf8 stream decoder modules
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define U8SD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/u8sd_pkg.sv
// types, constants and helpers shared by the utf8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

  // code point limits
  localparam logic [20:0] REPL_CP = 21'h00FFFD;
  localparam logic [20:0] MAX_CP  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] MIN_2B  = 21'h000080;
  localparam logic [20:0] MIN_3B  = 21'h000800;
  localparam logic [20:0] MIN_4B  = 21'h010000;
  localparam logic [20:0] BMP_MAX = 21'h00FFFF;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic [2:0]  seq_bytes;
    logic [1:0]  utf16_units;
    logic        last_of_run;
    logic        text_done;
  } out_word_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic use_input;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic more;
  } dp_sts_t;

  // sequence length opened by a lead byte, zero for a bad lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: design/u8sd_ctrl.sv
// controller: sequences byte intake and result delivery
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module u8sd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output u8sd_pkg::dp_cmd_t      cmd,
  input  wire u8sd_pkg::dp_sts_t sts
);

  u8sd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  // output register can take a new word this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.use_input = 1'b0;
    cmd.commit    = 1'b0;
    cmd.load_out  = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      u8sd_pkg::ST_IDLE: begin
        cmd.use_input = 1'b1;
        in_stall      = !slot_free;
        if (in_valid && slot_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = sts.has_result;
          if (sts.has_result && sts.more) begin
            state_nxt = u8sd_pkg::ST_RUN;
          end
        end
      end
      u8sd_pkg::ST_RUN: begin
        if (slot_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = 1'b1;
          if (!sts.more) begin
            state_nxt = u8sd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = u8sd_pkg::ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= u8sd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `U8SD_ASSERT(a_run_holds_word, state_r == u8sd_pkg::ST_RUN |-> out_valid_r, "run state without a pending word")
  `U8SD_ASSERT(a_run_has_result, state_r == u8sd_pkg::ST_RUN |-> sts.has_result, "run state with nothing to emit")
  `U8SD_NEVER(a_no_overwrite, cmd.load_out && out_valid_r && out_stall, "stalled result word overwritten")

endmodule

`default_nettype wire

FILE: design/u8sd_datapath.sv
// datapath: held byte window, sequence decoder and result register
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module u8sd_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u8sd_pkg::in_word_t  in_word,
  input  wire u8sd_pkg::dp_cmd_t   cmd,
  output u8sd_pkg::dp_sts_t        sts,
  output u8sd_pkg::out_word_t      out_word
);

  logic [3:0][7:0]     held_r, held_nxt;
  logic [2:0]          count_r, count_nxt;
  logic [2:0]          exp_len_r, exp_len_nxt;
  logic                eot_r;
  u8sd_pkg::out_word_t out_r;

  logic [3:0][7:0] view;
  logic [2:0]      view_cnt;
  logic            view_eot;
  logic [2:0]      front_len;
  logic [20:0]     val;
  logic [20:0]     min_val;
  logic            seq_ok;
  logic            range_ok;
  logic [20:0]     cp;
  logic            repl;
  logic [2:0]      nbytes;
  logic [2:0]      drop;
  logic [2:0]      rest_cnt;
  logic [2:0]      next_len;
  logic            has_result;
  logic            more;

  // window as seen this cycle: new byte appended while taking input
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      view[i] = (cmd.use_input && count_r[1:0] == 2'(i)) ? in_word.in_byte : held_r[i];
    end
    view_cnt  = cmd.use_input ? count_r + 3'd1 : count_r;
    view_eot  = cmd.use_input ? in_word.end_of_text : eot_r;
    front_len = (count_r != 3'd0) ? exp_len_r : u8sd_pkg::lead_length(in_word.in_byte);
  end

  // assemble the scalar value and check continuation bytes
  always_comb begin
    case (front_len)
      3'd2: begin
        val     = {10'd0, view[0][4:0], view[1][5:0]};
        seq_ok  = view[1][7:6] == 2'b10;
        min_val = u8sd_pkg::MIN_2B;
      end
      3'd3: begin
        val     = {5'd0, view[0][3:0], view[1][5:0], view[2][5:0]};
        seq_ok  = view[1][7:6] == 2'b10 && view[2][7:6] == 2'b10;
        min_val = u8sd_pkg::MIN_3B;
      end
      3'd4: begin
        val     = {view[0][2:0], view[1][5:0], view[2][5:0], view[3][5:0]};
        seq_ok  = view[1][7:6] == 2'b10 && view[2][7:6] == 2'b10
                  && view[3][7:6] == 2'b10;
        min_val = u8sd_pkg::MIN_4B;
      end
      default: begin
        val     = {13'd0, view[0]};
        seq_ok  = 1'b1;
        min_val = 21'd0;
      end
    endcase
    range_ok = val >= min_val && val <= u8sd_pkg::MAX_CP
               && !(val >= u8sd_pkg::SURR_LO && val <= u8sd_pkg::SURR_HI);
  end

  // decide the result for the front of the window
  always_comb begin
    has_result = 1'b1;
    cp         = u8sd_pkg::REPL_CP;
    repl       = 1'b1;
    nbytes     = 3'd1;
    drop       = 3'd1;
    if (front_len == 3'd1) begin
      cp   = {13'd0, view[0]};
      repl = 1'b0;
    end else if (front_len == 3'd0) begin
      has_result = 1'b1;
    end else if (view_cnt < front_len) begin
      // incomplete sequence waits unless the text ends here
      has_result = view_eot;
    end else if (seq_ok && range_ok) begin
      cp     = val;
      repl   = 1'b0;
      nbytes = front_len;
      drop   = front_len;
    end
    rest_cnt = view_cnt - drop;
    next_len = u8sd_pkg::lead_length(view[drop[1:0]]);
    more     = has_result && rest_cnt != 3'd0
               && (view_eot || next_len <= 3'd1 || rest_cnt >= next_len);
  end

  assign sts.has_result = has_result;
  assign sts.more       = more;

  // next window contents
  always_comb begin
    if (has_result) begin
      for (int i = 0; i < 4; i++) begin
        held_nxt[i] = view[2'(i) + drop[1:0]];
      end
      count_nxt   = rest_cnt;
      exp_len_nxt = (rest_cnt != 3'd0) ? next_len : 3'd0;
    end else begin
      held_nxt    = view;
      count_nxt   = view_cnt;
      exp_len_nxt = front_len;
    end
  end

  // window control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 3'd0;
      exp_len_r <= 3'd0;
    end else if (cmd.commit) begin
      count_r   <= count_nxt;
      exp_len_r <= exp_len_nxt;
    end
  end

  // window bytes and end mark
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      held_r <= held_nxt;
    end
    if (cmd.commit && cmd.use_input) begin
      eot_r <= in_word.end_of_text;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.code_point     <= cp;
      out_r.is_replacement <= repl;
      out_r.seq_bytes      <= nbytes;
      out_r.utf16_units    <= (cp > u8sd_pkg::BMP_MAX) ? 2'd2 : 2'd1;
      out_r.last_of_run    <= !more;
      out_r.text_done      <= !more && view_eot;
    end
  end

  assign out_word = out_r;

  // checks
  `U8SD_ASSERT(a_count_bound, count_r <= 3'd3, "held byte count out of range")
  `U8SD_ASSERT(a_wait_keeps_bytes, cmd.commit && !has_result |=> count_r != 3'd0, "waiting sequence lost its bytes")
  `U8SD_ASSERT(a_text_flushed, cmd.load_out && view_eot && !more |=> count_r == 3'd0, "bytes left after end of text")

endmodule

`default_nettype wire

FILE: design/utf8_stream_decoder.sv
// top level of the utf8 stream decoder
// latency: a result word is registered at the edge that takes the byte completing it
// throughput: one byte per cycle while each byte yields at most one result and the output is not stalled
// a byte yielding more than one result (error replays, end-of-text flush) stalls input while the further results go out
// the result register sets the pace: at most one word leaves per cycle
// reset (rst_n low, synchronous) empties the held window and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire u8sd_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output u8sd_pkg::out_word_t      out_word
);

  u8sd_pkg::dp_cmd_t cmd;
  u8sd_pkg::dp_sts_t sts;

  // sequencing
  u8sd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // decoding
  u8sd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
